FILE: rtl/core/bupi_pkg.sv
`default_nettype none

package bupi_pkg;

  localparam int TEMP_W = 16;
  localparam int POS_W = 4;
  localparam int SCALE_W = 24;
  localparam int INDEX_W = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 24;

  // fraction bits of index_scale
  localparam int SCALE_FRAC = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_TEMP    = 1'b0,
    REG_INDEX_SCALE = 1'b1
  } cfg_reg_t;

  // forward beat between the interpolator and the palette stages
  typedef struct packed {
    logic                     valid;
    logic signed [TEMP_W-1:0] temp;
  } temp_beat_t;

endpackage

`default_nettype wire

FILE: rtl/core/bupi_lerp.sv
`default_nettype none

module bupi_lerp #(
  parameter int TILE_SIZE = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [bupi_pkg::TEMP_W-1:0]  corner_a,
  input  logic signed [bupi_pkg::TEMP_W-1:0]  corner_b,
  input  logic signed [bupi_pkg::TEMP_W-1:0]  corner_c,
  input  logic signed [bupi_pkg::TEMP_W-1:0]  corner_d,
  input  logic        [bupi_pkg::POS_W-1:0]   sub_col,
  input  logic        [bupi_pkg::POS_W-1:0]   sub_row,
  input  logic                                hold_corner,
  output bupi_pkg::temp_beat_t                out_beat,
  input  logic                                out_ready
);

  localparam int TW = bupi_pkg::TEMP_W;
  localparam int DEN = TILE_SIZE * TILE_SIZE;
  localparam int SPAN_W = $clog2(TILE_SIZE + 1);
  localparam int WGT_W = $clog2(DEN + 1);
  localparam int NUM_W = TW + WGT_W;
  localparam int MAG_W = NUM_W - 1;
  localparam int SH = MAG_W + $clog2(DEN);
  localparam int RECIP_W = MAG_W + 1;
  localparam int QPROD_W = MAG_W + RECIP_W;
  // ceil(2^SH / DEN): exact floor division for every magnitude below 2^MAG_W
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SH) + 64'(DEN) - 64'd1) / 64'(DEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam logic [MAG_W-1:0] HALF = MAG_W'(DEN / 2);

  // stage enables, back to front
  logic en1, en2, en3, en4, en5;

  // position and weights
  logic [SPAN_W-1:0]   col_sat, row_sat, col_rem, row_rem;
  logic [2*SPAN_W-1:0] wa_full, wb_full, wc_full, wd_full;

  // stage 1: corners and weights
  logic                     s1_valid;
  logic signed [TW-1:0]     s1_a, s1_b, s1_c, s1_d;
  logic [WGT_W-1:0]         s1_wa, s1_wb, s1_wc, s1_wd;
  logic                     s1_hold;

  // stage 2: weighted corners
  logic                     s2_valid;
  logic signed [NUM_W-1:0]  s2_pa, s2_pb, s2_pc, s2_pd;
  logic signed [TW-1:0]     s2_a;
  logic                     s2_hold;

  // stage 3: rounded magnitude
  logic                     s3_valid;
  logic [MAG_W-1:0]         s3_mag;
  logic                     s3_neg;
  logic signed [TW-1:0]     s3_a;
  logic                     s3_hold;

  // stage 4: quotient
  logic                     s4_valid;
  logic [TW-1:0]            s4_q;
  logic                     s4_neg;
  logic signed [TW-1:0]     s4_a;
  logic                     s4_hold;

  // stage 5: result
  logic                     s5_valid;
  logic signed [TW-1:0]     s5_temp;

  logic signed [NUM_W-1:0]  num_sum;
  logic [NUM_W-1:0]         num_abs;
  logic [QPROD_W-1:0]       qprod;

  assign en5 = !s5_valid || out_ready;
  assign en4 = !s4_valid || en5;
  assign en3 = !s3_valid || en4;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign in_ready = en1;

  always_comb begin
    col_sat = (int'(sub_col) >= TILE_SIZE) ? SPAN_W'(TILE_SIZE - 1) : SPAN_W'(sub_col);
    row_sat = (int'(sub_row) >= TILE_SIZE) ? SPAN_W'(TILE_SIZE - 1) : SPAN_W'(sub_row);
    col_rem = SPAN_W'(TILE_SIZE) - col_sat;
    row_rem = SPAN_W'(TILE_SIZE) - row_sat;
    wa_full = {{SPAN_W{1'b0}}, col_rem} * {{SPAN_W{1'b0}}, row_rem};
    wb_full = {{SPAN_W{1'b0}}, col_sat} * {{SPAN_W{1'b0}}, row_rem};
    wc_full = {{SPAN_W{1'b0}}, col_rem} * {{SPAN_W{1'b0}}, row_sat};
    wd_full = {{SPAN_W{1'b0}}, col_sat} * {{SPAN_W{1'b0}}, row_sat};
  end

  always_comb begin
    num_sum = s2_pa + s2_pb + s2_pc + s2_pd;
    num_abs = num_sum[NUM_W-1] ? -num_sum : num_sum;
    qprod = QPROD_W'(s3_mag) * QPROD_W'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= in_valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
      if (en4) s4_valid <= s3_valid;
      if (en5) s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_a <= corner_a;
      s1_b <= corner_b;
      s1_c <= corner_c;
      s1_d <= corner_d;
      s1_wa <= wa_full[WGT_W-1:0];
      s1_wb <= wb_full[WGT_W-1:0];
      s1_wc <= wc_full[WGT_W-1:0];
      s1_wd <= wd_full[WGT_W-1:0];
      s1_hold <= hold_corner;
    end
    if (en2) begin
      s2_pa <= NUM_W'(s1_a * $signed({1'b0, s1_wa}));
      s2_pb <= NUM_W'(s1_b * $signed({1'b0, s1_wb}));
      s2_pc <= NUM_W'(s1_c * $signed({1'b0, s1_wc}));
      s2_pd <= NUM_W'(s1_d * $signed({1'b0, s1_wd}));
      s2_a <= s1_a;
      s2_hold <= s1_hold;
    end
    if (en3) begin
      // ties round away from zero
      s3_mag <= num_abs[MAG_W-1:0] + HALF;
      s3_neg <= num_sum[NUM_W-1];
      s3_a <= s2_a;
      s3_hold <= s2_hold;
    end
    if (en4) begin
      s4_q <= qprod[SH +: TW];
      s4_neg <= s3_neg;
      s4_a <= s3_a;
      s4_hold <= s3_hold;
    end
    if (en5) begin
      if (s4_hold) begin
        s5_temp <= s4_a;
      end else if (s4_neg) begin
        s5_temp <= -s4_q;
      end else begin
        s5_temp <= s4_q;
      end
    end
  end

  assign out_beat.valid = s5_valid;
  assign out_beat.temp = s5_temp;

  a_pos_quot_fits: assert property (@(posedge clk) disable iff (rst)
    s4_valid && !s4_neg |-> !s4_q[TW-1])
    else $error("positive quotient overflows the temperature range");

  a_neg_quot_fits: assert property (@(posedge clk) disable iff (rst)
    s4_valid && s4_neg |-> !s4_q[TW-1] || s4_q[TW-2:0] == '0)
    else $error("negative quotient overflows the temperature range");

  a_mid_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s4_valid && !en5 |=> s4_valid && $stable(s4_q) && $stable(s4_neg))
    else $error("stalled quotient stage lost its beat");

endmodule

`default_nettype wire

FILE: rtl/core/bilinear_upscale_palette_index.sv
// channel  direction  beat payload                                       handshake
// in       input      corner_a..d, sub_col, sub_row, hold_corner         in_valid / in_ready
// out      output     interp_temp, palette_index, index_clamped          out_valid / out_ready
// cfg      input      cfg_index, cfg_data                                cfg_we
//
// one beat per clock sustained while out_ready stays high
// eight register stages: weights, corner products, rounding, reciprocal multiply,
// sign/hold select, offset subtract, scale multiply, clamp
// rst (synchronous) empties the pipeline and clears min_temp and index_scale to 0
// every stage has its own valid bit and advances when the stage after it is free,
// so bubbles close up under a stall; the input stays ready while the output waits
// until all eight stages hold a beat
`default_nettype none

module bilinear_upscale_palette_index #(
  parameter int TILE_SIZE = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [bupi_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [bupi_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [bupi_pkg::TEMP_W-1:0]     corner_a,
  input  logic signed [bupi_pkg::TEMP_W-1:0]     corner_b,
  input  logic signed [bupi_pkg::TEMP_W-1:0]     corner_c,
  input  logic signed [bupi_pkg::TEMP_W-1:0]     corner_d,
  input  logic        [bupi_pkg::POS_W-1:0]      sub_col,
  input  logic        [bupi_pkg::POS_W-1:0]      sub_row,
  input  logic                                   hold_corner,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [bupi_pkg::TEMP_W-1:0]     interp_temp,
  output logic        [bupi_pkg::INDEX_W-1:0]    palette_index,
  output logic                                   index_clamped
);

  localparam int TW = bupi_pkg::TEMP_W;
  localparam int SW = bupi_pkg::SCALE_W;
  localparam int IW = bupi_pkg::INDEX_W;
  localparam int FRAC = bupi_pkg::SCALE_FRAC;
  localparam int DIFF_W = TW + 1;
  localparam int IPROD_W = DIFF_W + SW + 1;

  logic signed [TW-1:0] min_temp;
  logic [SW-1:0]        index_scale;

  bupi_pkg::temp_beat_t lerp_beat;
  logic                 en6, en7, en8;

  // stage 6: offset from the frame minimum
  logic                     s6_valid;
  logic signed [TW-1:0]     s6_temp;
  logic signed [DIFF_W-1:0] s6_diff;

  // stage 7: scaled offset
  logic                      s7_valid;
  logic signed [TW-1:0]      s7_temp;
  logic signed [IPROD_W-1:0] s7_prod;

  // stage 8: output register
  logic                 s8_valid;
  logic signed [TW-1:0] s8_temp;
  logic [IW-1:0]        s8_index;
  logic                 s8_clamped;

  logic over_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_temp <= '0;
      index_scale <= '0;
    end else if (cfg_we) begin
      case (bupi_pkg::cfg_reg_t'(cfg_index))
        bupi_pkg::REG_MIN_TEMP: min_temp <= cfg_data[TW-1:0];
        bupi_pkg::REG_INDEX_SCALE: index_scale <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  bupi_lerp #(
    .TILE_SIZE(TILE_SIZE)
  ) u_lerp (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .corner_a   (corner_a),
    .corner_b   (corner_b),
    .corner_c   (corner_c),
    .corner_d   (corner_d),
    .sub_col    (sub_col),
    .sub_row    (sub_row),
    .hold_corner(hold_corner),
    .out_beat   (lerp_beat),
    .out_ready  (en6)
  );

  assign en8 = !s8_valid || out_ready;
  assign en7 = !s7_valid || en8;
  assign en6 = !s6_valid || en7;

  // anything above the eight index bits means the index ran past the top
  assign over_top = |s7_prod[IPROD_W-2:FRAC+IW];

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
    end else begin
      if (en6) s6_valid <= lerp_beat.valid;
      if (en7) s7_valid <= s6_valid;
      if (en8) s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_temp <= lerp_beat.temp;
      s6_diff <= DIFF_W'(lerp_beat.temp) - DIFF_W'(min_temp);
    end
    if (en7) begin
      s7_temp <= s6_temp;
      s7_prod <= IPROD_W'(s6_diff * $signed({1'b0, index_scale}));
    end
    if (en8) begin
      s8_temp <= s7_temp;
      if (s7_prod[IPROD_W-1]) begin
        s8_index <= '0;
        s8_clamped <= 1'b1;
      end else if (over_top) begin
        s8_index <= '1;
        s8_clamped <= 1'b1;
      end else begin
        s8_index <= s7_prod[FRAC +: IW];
        s8_clamped <= 1'b0;
      end
    end
  end

  assign out_valid = s8_valid;
  assign interp_temp = s8_temp;
  assign palette_index = s8_index;
  assign index_clamped = s8_clamped;

  a_clamp_at_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_clamped |-> palette_index == '0 || palette_index == '1)
    else $error("clamped index is not at a rail");

  a_interior_not_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid && palette_index != '0 && palette_index != '1 |-> !index_clamped)
    else $error("interior index flagged as clamped");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  a_scale_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s7_valid && !en8 |=> s7_valid && $stable(s7_prod) && $stable(s7_temp))
    else $error("stalled scale stage lost its beat");

endmodule

`default_nettype wire
